[rtl/stq_pkg.sv]
// Shared types, constants and codes for the sorted timer queue.
package stq_pkg;

  localparam int CAPACITY     = 16;
  localparam int RESULT_LIMIT = 16;
  localparam int TAG_W        = 16;
  localparam int TIME_W       = 32;
  localparam int CNT_W        = $clog2(CAPACITY + 1);
  localparam int NUM_W        = $clog2(RESULT_LIMIT);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_ADJUST = 2'd1,
    OP_DELETE = 2'd2,
    OP_TICK   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_PRESENT   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REINS
  } ctrl_state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_POP
  } cell_cmd_t;

  // Command broadcast from the sequencer to every cell
  typedef struct packed {
    cell_cmd_t           cmd;
    logic [TAG_W-1:0]    key_tag;
    logic [TIME_W-1:0]   key_exp;
  } cell_ctrl_t;

  // What the sequencer sees of the cell row
  typedef struct packed {
    logic [TAG_W-1:0]    head_tag;
    logic [TIME_W-1:0]   head_exp;
    logic [TIME_W-1:0]   next_exp;
    logic                match_any;
  } head_view_t;

endpackage

[rtl/stq_cell.sv]
// One slot of the sorted row: holds a timer and shifts toward either neighbor.
module stq_cell (
  input  logic                        clk,
  input  stq_pkg::cell_ctrl_t         ctrl,
  input  logic                        occ,
  input  logic                        left_gt,
  input  logic [stq_pkg::TAG_W-1:0]   left_tag,
  input  logic [stq_pkg::TIME_W-1:0]  left_exp,
  input  logic [stq_pkg::TAG_W-1:0]   right_tag,
  input  logic [stq_pkg::TIME_W-1:0]  right_exp,
  input  logic                        match_in,
  output logic                        gt,
  output logic                        match_out,
  output logic [stq_pkg::TAG_W-1:0]   tag,
  output logic [stq_pkg::TIME_W-1:0]  expiry
);
  import stq_pkg::*;

  logic [TAG_W-1:0]  tag_next;
  logic [TIME_W-1:0] expiry_next;

  // An empty slot counts as later than any key, so the flags stay monotonic
  assign gt        = occ ? (expiry > ctrl.key_exp) : 1'b1;
  assign match_out = match_in | (occ & (tag == ctrl.key_tag));

  // Pick the new contents from self, the key or a neighbor
  always_comb begin
    tag_next    = tag;
    expiry_next = expiry;
    unique case (ctrl.cmd)
      CELL_INSERT: begin
        if (left_gt) begin
          tag_next    = left_tag;
          expiry_next = left_exp;
        end else if (gt) begin
          tag_next    = ctrl.key_tag;
          expiry_next = ctrl.key_exp;
        end
      end
      CELL_REMOVE: begin
        if (match_out) begin
          tag_next    = right_tag;
          expiry_next = right_exp;
        end
      end
      CELL_POP: begin
        tag_next    = right_tag;
        expiry_next = right_exp;
      end
      default: begin
        tag_next    = tag;
        expiry_next = expiry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    tag    <= tag_next;
    expiry <= expiry_next;
  end

endmodule

[rtl/stq_ctrl.sv]
// Operation sequencer, entry count and result register of the timer queue.
module stq_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [1:0]                  s_opcode,
  input  logic [stq_pkg::TAG_W-1:0]   s_tag,
  input  logic [stq_pkg::TIME_W-1:0]  s_exp,
  input  logic [stq_pkg::TIME_W-1:0]  s_now,
  input  stq_pkg::head_view_t         view,
  output stq_pkg::cell_ctrl_t         ctrl,
  output logic [stq_pkg::CNT_W-1:0]   count,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [1:0]                  out_status,
  output logic                        out_xvalid,
  output logic [stq_pkg::TAG_W-1:0]   out_tag,
  output logic                        out_last
);
  import stq_pkg::*;

  ctrl_state_t       state, state_next;
  opcode_t           op;
  logic [TAG_W-1:0]  tag_r;
  logic [TIME_W-1:0] exp_r;
  logic [TIME_W-1:0] now_r;
  logic [CNT_W-1:0]  count_next;
  logic [NUM_W-1:0]  n_emit, n_emit_next;
  cell_cmd_t         cmd;
  logic              out_free;
  logic              load_out;
  status_t           res_status;
  logic              res_xvalid;
  logic [TAG_W-1:0]  res_tag;
  logic              res_last;
  logic              head_due;
  logic              next_due;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign head_due = (count != '0) && (view.head_exp <= now_r);
  assign next_due = (count > CNT_W'(1)) && (view.next_exp <= now_r);

  assign ctrl.cmd     = cmd;
  assign ctrl.key_tag = tag_r;
  assign ctrl.key_exp = exp_r;

  // Latch the operation on each input transfer
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op    <= opcode_t'(s_opcode);
      tag_r <= s_tag;
      exp_r <= s_exp;
      now_r <= s_now;
    end
  end

  // Next state, cell command and result
  always_comb begin
    state_next  = state;
    count_next  = count;
    n_emit_next = n_emit;
    cmd         = CELL_HOLD;
    load_out    = 1'b0;
    res_status  = STAT_OK;
    res_xvalid  = 1'b0;
    res_tag     = '0;
    res_last    = 1'b1;
    unique case (state)
      S_IDLE: begin
        n_emit_next = '0;
        if (s_tvalid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          load_out = 1'b1;
          unique case (op)
            OP_ADD: begin
              state_next = S_IDLE;
              if (view.match_any) begin
                res_status = STAT_PRESENT;
              end else if (count == CNT_W'(CAPACITY)) begin
                res_status = STAT_FULL;
              end else begin
                cmd        = CELL_INSERT;
                count_next = count + CNT_W'(1);
              end
            end
            OP_ADJUST: begin
              if (view.match_any) begin
                cmd        = CELL_REMOVE;
                count_next = count - CNT_W'(1);
                state_next = S_REINS;
              end else begin
                res_status = STAT_NOT_FOUND;
                state_next = S_IDLE;
              end
            end
            OP_DELETE: begin
              state_next = S_IDLE;
              if (view.match_any) begin
                cmd        = CELL_REMOVE;
                count_next = count - CNT_W'(1);
              end else begin
                res_status = STAT_NOT_FOUND;
              end
            end
            OP_TICK: begin
              if (head_due) begin
                // Pop the head; stop after this one if the next is not due or the result limit is reached
                cmd         = CELL_POP;
                count_next  = count - CNT_W'(1);
                n_emit_next = n_emit + NUM_W'(1);
                res_xvalid  = 1'b1;
                res_tag     = view.head_tag;
                res_last    = !next_due || (n_emit == NUM_W'(RESULT_LIMIT - 1));
                if (res_last) begin
                  state_next = S_IDLE;
                end
              end else begin
                state_next = S_IDLE;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_REINS: begin
        // Put the adjusted timer back at its new place
        cmd        = CELL_INSERT;
        count_next = count + CNT_W'(1);
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      n_emit <= '0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      n_emit <= n_emit_next;
    end
  end

  // Result register: load when free, drop after the output transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= res_status;
      out_xvalid <= res_xvalid;
      out_tag    <= res_tag;
      out_last   <= res_last;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_expired_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_xvalid) |-> (out_status == STAT_OK))
    else $error("expired result with error status");

  a_plain_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_xvalid) |-> out_last)
    else $error("non-expiry result not marked last");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (cmd == CELL_POP) |=> (count == $past(count) - CNT_W'(1)))
    else $error("pop did not shrink the count");

endmodule

[rtl/sorted_timer_queue_top.sv]
// Top level of the sorted timer queue: sequencer plus the row of timer cells.
// Holds up to 16 timers (16-bit tag, 32-bit expiry) in a row of cells sorted
// by ascending expiry; a new or adjusted timer lands after equal expiries.
// tuser selects the operation: add, adjust, delete or tick. An adjust is a
// remove followed by a re-insert as a second shift of the row, and a tick
// pops expired timers from the head, one result per cycle while the result
// port is ready, since the row shifts by one cell per pop. A stalled result
// port holds the operation, and no new one is taken until it is done. A tick
// reports at most 16 timers; any further due timers are reported by the next tick.
module sorted_timer_queue_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,  // [15:0] timer_tag, [47:16] expire_time, [79:48] now_time
  input  logic [1:0]  s_tuser,  // [1:0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // [1:0] status, [17:2] expired_tag, [23:18] zero
  output logic        m_tuser,  // [0] expired_valid
  output logic        m_tlast
);
  import stq_pkg::*;

  cell_ctrl_t        ctrl;
  head_view_t        view;
  logic [CNT_W-1:0]  count;
  logic [1:0]        out_status;
  logic [TAG_W-1:0]  out_tag;
  logic              occ   [CAPACITY];
  logic              gt    [CAPACITY];
  logic              mthru [CAPACITY];
  logic [TAG_W-1:0]  ctag  [CAPACITY];
  logic [TIME_W-1:0] cexp  [CAPACITY];

  stq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_opcode   (s_tuser),
    .s_tag      (s_tdata[15:0]),
    .s_exp      (s_tdata[47:16]),
    .s_now      (s_tdata[79:48]),
    .view       (view),
    .ctrl       (ctrl),
    .count      (count),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .out_status (out_status),
    .out_xvalid (m_tuser),
    .out_tag    (out_tag),
    .out_last   (m_tlast)
  );

  assign m_tdata = {6'd0, out_tag, out_status};

  // Head of the row for ticks, and the tag search result
  assign view.head_tag  = ctag[0];
  assign view.head_exp  = cexp[0];
  assign view.next_exp  = cexp[1];
  assign view.match_any = mthru[CAPACITY-1];

  // Row of cells; each trades data with its two neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic              l_gt;
    logic [TAG_W-1:0]  l_tag;
    logic [TIME_W-1:0] l_exp;
    logic [TAG_W-1:0]  r_tag;
    logic [TIME_W-1:0] r_exp;
    logic              m_in;

    assign occ[i] = (CNT_W'(i) < count);

    if (i == 0) begin : g_first
      assign l_gt  = 1'b0;
      assign l_tag = ctrl.key_tag;
      assign l_exp = ctrl.key_exp;
      assign m_in  = 1'b0;
    end else begin : g_inner
      assign l_gt  = gt[i-1];
      assign l_tag = ctag[i-1];
      assign l_exp = cexp[i-1];
      assign m_in  = mthru[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign r_tag = ctag[i];
      assign r_exp = cexp[i];
    end else begin : g_mid
      assign r_tag = ctag[i+1];
      assign r_exp = cexp[i+1];
    end

    stq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (occ[i]),
      .left_gt   (l_gt),
      .left_tag  (l_tag),
      .left_exp  (l_exp),
      .right_tag (r_tag),
      .right_exp (r_exp),
      .match_in  (m_in),
      .gt        (gt[i]),
      .match_out (mthru[i]),
      .tag       (ctag[i]),
      .expiry    (cexp[i])
    );
  end

endmodule

[verif/timer_queue_checker.sv]
// Scoreboard for the sorted timer queue: watches both streams, predicts and compares results.
module timer_queue_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [79:0] s_tdata,   // [15:0] timer_tag, [47:16] expire_time, [79:48] now_time
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,   // [1:0] status, [17:2] expired_tag, [23:18] zero
  input  logic        m_tuser,   // [0] expired_valid
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending,
  output int          results_checked,
  output int          expiries_checked,
  output int          errors_checked
);
  import stq_pkg::*;

  typedef struct packed {
    status_t          status;
    logic             fired;
    logic [TAG_W-1:0] tag;
    logic             last;
  } timer_result_t;

  // Expected results in arrival order, and the predicted timer list
  timer_result_t     due_results[$];
  logic [TAG_W-1:0]  held_tag [CAPACITY];
  logic [TIME_W-1:0] held_exp [CAPACITY];
  int                held_count;

  task automatic report_mismatch(string what);
    $display("%0t mismatch at result %0d: %s", $time, results_checked, what);
    fail_count++;
  endtask

  // Position of a tag in the list, -1 when absent
  function automatic int find_held(logic [TAG_W-1:0] tag);
    for (int i = 0; i < held_count; i++) begin
      if (held_tag[i] == tag) return i;
    end
    return -1;
  endfunction

  // Close the gap left by a removed entry
  function automatic void drop_held(int pos);
    for (int i = pos; i + 1 < held_count; i++) begin
      held_tag[i] = held_tag[i+1];
      held_exp[i] = held_exp[i+1];
    end
    held_count--;
  endfunction

  // Insert after every entry whose expiry is not later; caller checks for room
  function automatic void place_held(logic [TAG_W-1:0] tag, logic [TIME_W-1:0] expiry);
    int pos;
    pos = 0;
    while (pos < held_count && held_exp[pos] <= expiry) pos++;
    for (int i = held_count; i > pos; i--) begin
      held_tag[i] = held_tag[i-1];
      held_exp[i] = held_exp[i-1];
    end
    held_tag[pos] = tag;
    held_exp[pos] = expiry;
    held_count++;
  endfunction

  // Apply one operation to the list and queue the results it must produce
  function automatic void predict_timer_op(opcode_t op, logic [TAG_W-1:0] tag,
                                           logic [TIME_W-1:0] expiry,
                                           logic [TIME_W-1:0] now);
    logic [TAG_W-1:0] fired_tags[$];
    status_t          st;
    int               pos;
    logic             is_last;
    st = STAT_OK;
    if (op == OP_TICK) begin
      while (fired_tags.size() < RESULT_LIMIT && held_count > 0 && held_exp[0] <= now) begin
        fired_tags.push_back(held_tag[0]);
        drop_held(0);
      end
      if (fired_tags.size() == 0) due_results.push_back('{STAT_OK, 1'b0, '0, 1'b1});
      foreach (fired_tags[i]) begin
        is_last = (i == fired_tags.size() - 1);
        due_results.push_back('{STAT_OK, 1'b1, fired_tags[i], is_last});
      end
    end else begin
      pos = find_held(tag);
      case (op)
        OP_ADD: begin
          if (pos >= 0) st = STAT_PRESENT;
          else if (held_count >= CAPACITY) st = STAT_FULL;
          else place_held(tag, expiry);
        end
        OP_ADJUST: begin
          if (pos < 0) st = STAT_NOT_FOUND;
          else begin
            drop_held(pos);
            place_held(tag, expiry);
          end
        end
        default: begin
          if (pos < 0) st = STAT_NOT_FOUND;
          else drop_held(pos);
        end
      endcase
      due_results.push_back('{st, 1'b0, '0, 1'b1});
    end
  endfunction

  always @(posedge clk) begin : watch
    timer_result_t want;
    if (rst) begin
      due_results.delete();
      held_count       = 0;
      fail_count       = 0;
      results_checked  = 0;
      expiries_checked = 0;
      errors_checked   = 0;
    end else begin
      // A result transfer at this edge is older than an input taken at the same edge
      if (m_tvalid && m_tready) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected (tag %h)", m_tdata[17:2]));
        end else begin
          want = due_results.pop_front();
          if (m_tdata[1:0] != want.status)
            report_mismatch($sformatf("status got %0d want %0d", m_tdata[1:0], want.status));
          if (m_tuser != want.fired)
            report_mismatch($sformatf("expired_valid got %0b want %0b", m_tuser, want.fired));
          if (m_tdata[17:2] != want.tag)
            report_mismatch($sformatf("expired_tag got %h want %h", m_tdata[17:2], want.tag));
          if (m_tlast != want.last)
            report_mismatch($sformatf("last got %0b want %0b", m_tlast, want.last));
          results_checked++;
          if (want.fired) expiries_checked++;
          if (want.status != STAT_OK) errors_checked++;
        end
      end
      if (s_tvalid && s_tready)
        predict_timer_op(opcode_t'(s_tuser), s_tdata[15:0], s_tdata[47:16], s_tdata[79:48]);
    end
    pending = due_results.size();
  end

endmodule

[verif/tb_sorted_timer_queue_top.sv]
// Testbench top for the sorted timer queue: stimulus, handshake idling and the verdict.
module tb_sorted_timer_queue_top;
  import stq_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int POOL_SIZE   = 24;
  localparam int PHASE_ITEMS = 112;
  localparam int FILL_ITEMS  = 18;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  int fail_count;
  int pending;
  int results_checked;
  int expiries_checked;
  int errors_checked;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int ops_sent      = 0;

  logic [TAG_W-1:0]  tag_pool [POOL_SIZE];
  logic [TIME_W-1:0] clock_now;

  always #5 clk = ~clk;

  sorted_timer_queue_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  timer_queue_checker scoreboard (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .s_tuser          (s_tuser),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tuser          (m_tuser),
    .m_tlast          (m_tlast),
    .fail_count       (fail_count),
    .pending          (pending),
    .results_checked  (results_checked),
    .expiries_checked (expiries_checked),
    .errors_checked   (errors_checked)
  );

  // Stall the result port at the current phase's rate
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_count, pending);
      $display("status: fail");
      $finish;
    end
  end

  // Present one operation, idling first at the phase's rate; return at its transfer edge
  task automatic send_op(opcode_t op, logic [TAG_W-1:0] tag, logic [TIME_W-1:0] expiry,
                         logic [TIME_W-1:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {now, expiry, tag};
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    ops_sent++;
  endtask

  // Mostly pool tags and near-term expiries so that timers collide, expire and get reused
  task automatic random_op();
    int                pick;
    opcode_t           op;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] expiry;
    logic [TIME_W-1:0] now;
    pick   = $urandom_range(99);
    tag    = ($urandom_range(9) == 0) ? TAG_W'($urandom) : tag_pool[$urandom_range(POOL_SIZE-1)];
    expiry = clock_now + $urandom_range(40);
    now    = $urandom;
    case ($urandom_range(19))
      0:       expiry = $urandom;
      1:       expiry = '0;
      2:       expiry = '1;
      default: ;
    endcase
    if (pick < 38) op = OP_ADD;
    else if (pick < 52) op = OP_ADJUST;
    else if (pick < 64) op = OP_DELETE;
    else begin
      op        = OP_TICK;
      clock_now = clock_now + $urandom_range(12);
      case ($urandom_range(29))
        0:       now = '1;
        1:       now = $urandom;
        default: now = clock_now;
      endcase
      tag    = TAG_W'($urandom);
      expiry = $urandom;
    end
    send_op(op, tag, expiry, now);
  endtask

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) tag_pool[i] = TAG_W'($urandom);
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty list, absent tags, extremes, ties, both adjust directions, full list
    send_op(OP_TICK, TAG_W'($urandom), $urandom, '0);
    send_op(OP_DELETE, 16'h1234, $urandom, $urandom);
    send_op(OP_ADJUST, 16'h1234, 32'd7, $urandom);
    send_op(OP_ADD, 16'h0000, '1, $urandom);
    send_op(OP_ADD, 16'hFFFF, '0, $urandom);
    send_op(OP_ADD, 16'hFFFF, 32'd9, $urandom);
    send_op(OP_ADD, 16'h0100, '0, $urandom);
    send_op(OP_ADJUST, 16'h0000, '0, $urandom);
    send_op(OP_ADJUST, 16'h0100, '1, $urandom);
    for (int i = 0; i < 13; i++)
      send_op(OP_ADD, TAG_W'(16'h2000 + i * 16'h0101), TIME_W'(i / 2), $urandom);
    send_op(OP_ADD, 16'h7777, 32'd3, $urandom);
    send_op(OP_ADD, 16'hFFFF, 32'd3, $urandom);
    send_op(OP_TICK, TAG_W'($urandom), $urandom, 32'd1);
    send_op(OP_TICK, TAG_W'($urandom), $urandom, '1);

    // Random phases with different idling on each side
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 47; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 47; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      clock_now = $urandom;
      // flush leftovers from the last phase, then fill the list to capacity and beyond
      send_op(OP_TICK, TAG_W'($urandom), $urandom, '1);
      for (int k = 0; k < FILL_ITEMS; k++)
        send_op(OP_ADD, tag_pool[$urandom_range(POOL_SIZE-1)],
                clock_now + $urandom_range(40), $urandom);
      for (int k = 0; k < PHASE_ITEMS - FILL_ITEMS - 1; k++) random_op();
    end
    s_tvalid <= 1'b0;

    // Drain, then allow time for any stray result
    do @(negedge clk); while (pending != 0);
    repeat (40) @(posedge clk);

    $display("Ran %0d timer operations: a directed pass, then four idling phases.",
             ops_sent);
    $display("Checked %0d results: %0d expired timers, %0d refused operations, %0d mismatches.",
             results_checked, expiries_checked, errors_checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
